### src/stbe_pkg.sv
// Shared types, register codes and helpers for the spanning-tree config engine.
// No dependencies.
`default_nettype none
package stbe_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_OWN_ID     = 2'd0,
    REG_PORT_PRIO  = 2'd1,
    REG_PORTS_USED = 2'd2,
    REG_PATH_COST  = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_RX_RD,
    S_RX_CMP,
    S_EL_RD,
    S_EL_EV,
    S_ROOT,
    S_UP_RD,
    S_UP_EV,
    S_EM_START,
    S_EMIT
  } state_e;

  // Priority vector; field order makes a plain unsigned compare lexicographic.
  typedef struct packed {
    logic [63:0] root;
    logic [31:0] cost;
    logic [63:0] sw;
    logic [15:0] port;
  } vec_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;
    logic rd;
    logic rd_rx;
    logic wr_rx;
    logic best_clr;
    logic el_eval;
    logic root_set;
    logic upd_eval;
    logic emit_start;
    logic emit_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic mode;
    logic rx_active;
    logic hello_en;
    logic rx_better;
    logic rx_equal;
    logic rem_empty;
    logic out_free;
  } status_t;

  localparam int unsigned MaxOut = 8;
  localparam logic [31:0] CostMax = 32'hFFFF_FFFF;

  function automatic logic [15:0] local_pid(logic [7:0] prio, logic [7:0] idx);
    local_pid = {prio, idx + 8'd1};
  endfunction

endpackage
`default_nettype wire

### src/spanning_tree_bpdu_engine.sv
// Spanning-tree config message engine: top level joining controller and datapath.
// Depends on stbe_pkg, stbe_ctrl, stbe_dp.
//
// One item is taken at a time. A hello tick goes straight to the emit run,
// or ends there when the hello timer is off. A received message first has
// its port's stored vector looked up and compared; an equal one or one on an
// inactive port ends there. If it is better, the port table is walked twice
// (root port election, then designated port update), reading each active
// port through the single-port vector memory, with the root cost set between
// the walks, then the emit run. A worse message goes straight to the emit
// run. A finished result that waits on out_ready_i holds up the emit run.
// Results go out through an output register, so the last result of one item
// may still wait while the next item is taken.
// Messages are sent in ascending port order on designated ports among the
// first eight active ports; last marks the final one. The vector table needs
// no clearing pass: per-entry valid bits make unwritten entries read as the
// reset vector, and writing own_switch_id or port_priority resets every entry.
`default_nettype none
module spanning_tree_bpdu_engine #(
  parameter int PORTS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        mode_i,
  input  wire logic [2:0]  rx_port_i,
  input  wire logic [63:0] rx_root_id_i,
  input  wire logic [31:0] rx_root_cost_i,
  input  wire logic [63:0] rx_switch_id_i,
  input  wire logic [15:0] rx_sender_port_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       tx_port_o,
  output logic [63:0]      tx_root_id_o,
  output logic [31:0]      tx_root_cost_o,
  output logic [63:0]      tx_switch_id_o,
  output logic [15:0]      tx_port_id_o,
  output logic             root_port_valid_o,
  output logic [2:0]       root_port_index_o,
  output logic             last_o
);
  import stbe_pkg::*;

  localparam int CW = $clog2(PORTS + 1);

  cmd_t          cmd;
  status_t       status;
  logic [CW-1:0] idx;
  logic [CW-1:0] n_act;

  stbe_ctrl #(.PORTS(PORTS)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .n_act_i    (n_act),
    .cmd_o      (cmd),
    .idx_o      (idx)
  );

  stbe_dp #(.PORTS(PORTS)) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .mode_i            (mode_i),
    .rx_port_i         (rx_port_i),
    .rx_root_id_i      (rx_root_id_i),
    .rx_root_cost_i    (rx_root_cost_i),
    .rx_switch_id_i    (rx_switch_id_i),
    .rx_sender_port_i  (rx_sender_port_i),
    .cmd_i             (cmd),
    .idx_i             (idx),
    .status_o          (status),
    .n_act_o           (n_act),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .tx_port_o         (tx_port_o),
    .tx_root_id_o      (tx_root_id_o),
    .tx_root_cost_o    (tx_root_cost_o),
    .tx_switch_id_o    (tx_switch_id_o),
    .tx_port_id_o      (tx_port_id_o),
    .root_port_valid_o (root_port_valid_o),
    .root_port_index_o (root_port_index_o),
    .last_o            (last_o)
  );

endmodule
`default_nettype wire

### src/stbe_dp.sv
// Datapath: port vector memory, root state, walk evaluation and output register.
// Depends on stbe_pkg.
`default_nettype none
module stbe_dp #(
  parameter int PORTS = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [1:0]                    cfg_index_i,
  input  wire logic [63:0]                   cfg_data_i,
  input  wire logic                          mode_i,
  input  wire logic [2:0]                    rx_port_i,
  input  wire logic [63:0]                   rx_root_id_i,
  input  wire logic [31:0]                   rx_root_cost_i,
  input  wire logic [63:0]                   rx_switch_id_i,
  input  wire logic [15:0]                   rx_sender_port_i,
  input  wire stbe_pkg::cmd_t                cmd_i,
  input  wire logic [$clog2(PORTS+1)-1:0]    idx_i,
  output stbe_pkg::status_t                  status_o,
  output logic [$clog2(PORTS+1)-1:0]         n_act_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [2:0]                         tx_port_o,
  output logic [63:0]                        tx_root_id_o,
  output logic [31:0]                        tx_root_cost_o,
  output logic [63:0]                        tx_switch_id_o,
  output logic [15:0]                        tx_port_id_o,
  output logic                               root_port_valid_o,
  output logic [2:0]                         root_port_index_o,
  output logic                               last_o
);
  import stbe_pkg::*;

  localparam int IW = $clog2(PORTS);
  localparam int CW = $clog2(PORTS + 1);

  // configuration
  logic [63:0] own_q;
  logic [7:0]  prio_q;
  logic [3:0]  piu_q;
  logic [15:0] path_cost_q;
  logic        ident_wr;

  // root state
  logic [63:0] cur_root_q;
  logic [31:0] root_cost_q;
  logic [IW-1:0] rpi_q;
  logic        rpv_q;
  logic        hello_q;

  // input latch
  logic        mode_q;
  logic [2:0]  rx_port_q;
  vec_t        rx_vec_q;

  // memory and per-entry flags
  vec_t        mem_q [PORTS];
  logic [PORTS-1:0] valid_q;
  logic [PORTS-1:0] desig_q;
  vec_t        rd_data_q;
  logic        rd_vld_q;
  logic [IW-1:0] rd_idx_q;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] rx_addr;

  // election
  vec_t        best_q;
  logic [IW-1:0] best_idx_q;
  logic        best_vld_q;

  // emit
  logic [MaxOut-1:0] rem_q;
  logic [MaxOut-1:0] mask;
  logic [MaxOut-1:0] pick;
  logic [2:0]        pick_idx;

  logic        out_vld_q;
  logic        out_free;

  vec_t        ent;
  vec_t        own_vec;
  logic [15:0] ent_pid;
  logic        cand;
  logic        take;
  logic        skip;
  logic        wr_en;
  logic [IW-1:0] wr_addr;
  vec_t        wr_data;
  logic        wr_desig;
  logic [32:0] cost_sum;
  logic [CW-1:0] n_act;

  assign ident_wr = cfg_we_i && (reg_e'(cfg_index_i) == REG_OWN_ID ||
                                 reg_e'(cfg_index_i) == REG_PORT_PRIO);

  assign n_act   = (int'(piu_q) > PORTS) ? CW'(PORTS) : CW'(piu_q);
  assign n_act_o = n_act;

  assign rx_addr = IW'(rx_port_q);
  assign rd_addr = cmd_i.rd_rx ? rx_addr : IW'(idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q       <= '0;
      prio_q      <= 8'd128;
      piu_q       <= 4'd8;
      path_cost_q <= 16'd1;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_OWN_ID:     own_q       <= cfg_data_i;
        REG_PORT_PRIO:  prio_q      <= cfg_data_i[7:0];
        REG_PORTS_USED: piu_q       <= cfg_data_i[3:0];
        REG_PATH_COST:  path_cost_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      mode_q    <= mode_i;
      rx_port_q <= rx_port_i;
      rx_vec_q  <= '{root: rx_root_id_i, cost: rx_root_cost_i,
                     sw: rx_switch_id_i, port: rx_sender_port_i};
    end
  end

  // entry that never got written reads as its reset vector
  assign ent_pid = local_pid(prio_q, 8'(rd_idx_q));
  assign ent = rd_vld_q ? rd_data_q
                        : '{root: own_q, cost: 32'd0, sw: own_q, port: ent_pid};
  assign own_vec = '{root: cur_root_q, cost: root_cost_q, sw: own_q, port: ent_pid};

  assign cand = !desig_q[rd_idx_q] && (ent.root < own_q);
  assign skip = rpv_q && (rd_idx_q == rpi_q);
  assign take = desig_q[rd_idx_q] || (ent.root != cur_root_q) ||
                (root_cost_q < ent.cost) ||
                ((root_cost_q == ent.cost) &&
                 ((own_q < ent.sw) || ((own_q == ent.sw) && (ent_pid <= ent.port))));

  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = rd_idx_q;
    wr_data  = own_vec;
    wr_desig = 1'b1;
    if (cmd_i.wr_rx) begin
      wr_en    = 1'b1;
      wr_addr  = rx_addr;
      wr_data  = rx_vec_q;
      wr_desig = (rx_vec_q.sw == own_q) &&
                 (rx_vec_q.port == local_pid(prio_q, 8'(rx_addr)));
    end else if (cmd_i.upd_eval && !skip && take) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (cmd_i.rd) begin
      rd_data_q <= mem_q[rd_addr];
      rd_idx_q  <= rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      desig_q  <= '1;
      rd_vld_q <= 1'b0;
    end else if (ident_wr) begin
      valid_q <= '0;
      desig_q <= '1;
    end else begin
      if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
        desig_q[wr_addr] <= wr_desig;
      end
      if (cmd_i.rd) rd_vld_q <= valid_q[rd_addr];
    end
  end

  // root port election
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_vld_q <= 1'b0;
    end else if (cmd_i.best_clr) begin
      best_vld_q <= 1'b0;
    end else if (cmd_i.el_eval && cand && (!best_vld_q || ent < best_q)) begin
      best_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.el_eval && cand && (!best_vld_q || ent < best_q)) begin
      best_q     <= ent;
      best_idx_q <= rd_idx_q;
    end
  end

  assign cost_sum = {1'b0, best_q.cost} + 33'(path_cost_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_root_q  <= '0;
      root_cost_q <= '0;
      rpi_q       <= '0;
      rpv_q       <= 1'b0;
      hello_q     <= 1'b1;
    end else if (ident_wr) begin
      cur_root_q  <= (reg_e'(cfg_index_i) == REG_OWN_ID) ? cfg_data_i : own_q;
      root_cost_q <= '0;
      rpi_q       <= '0;
      rpv_q       <= 1'b0;
      hello_q     <= 1'b1;
    end else if (cmd_i.root_set) begin
      if (best_vld_q) begin
        cur_root_q  <= best_q.root;
        root_cost_q <= cost_sum[32] ? CostMax : cost_sum[31:0];
        rpi_q       <= best_idx_q;
        rpv_q       <= 1'b1;
        if (cur_root_q == own_q) hello_q <= 1'b0;
      end else begin
        cur_root_q  <= own_q;
        root_cost_q <= '0;
        rpi_q       <= '0;
        rpv_q       <= 1'b0;
        if (cur_root_q != own_q) hello_q <= 1'b1;
      end
    end
  end

  // designated ports among the first eight active ones
  for (genvar g = 0; g < MaxOut; g++) begin : g_mask
    if (g < PORTS) begin : g_on
      assign mask[g] = (int'(n_act) > g) && desig_q[g] &&
                       !((cur_root_q != own_q) && !rpv_q);
    end else begin : g_off
      assign mask[g] = 1'b0;
    end
  end

  always_comb begin
    pick     = '0;
    pick_idx = '0;
    for (int i = MaxOut - 1; i >= 0; i--) begin
      if (rem_q[i]) begin
        pick     = '0;
        pick[i]  = 1'b1;
        pick_idx = 3'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (cmd_i.emit_start) begin
      rem_q <= mask;
    end else if (cmd_i.emit_load) begin
      rem_q <= rem_q & ~pick;
    end
  end

  assign out_free = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.emit_load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      tx_port_o         <= pick_idx;
      tx_root_id_o      <= cur_root_q;
      tx_root_cost_o    <= root_cost_q;
      tx_switch_id_o    <= own_q;
      tx_port_id_o      <= local_pid(prio_q, 8'(pick_idx));
      root_port_valid_o <= rpv_q;
      root_port_index_o <= rpv_q ? 3'(rpi_q) : 3'd0;
      last_o            <= (rem_q & ~pick) == '0;
    end
  end

  assign out_valid_o = out_vld_q;

  assign status_o.mode      = mode_q;
  assign status_o.rx_active = int'(rx_port_q) < int'(n_act);
  assign status_o.hello_en  = hello_q;
  assign status_o.rx_better = rx_vec_q < ent;
  assign status_o.rx_equal  = rx_vec_q == ent;
  assign status_o.rem_empty = rem_q == '0;
  assign status_o.out_free  = out_free;

endmodule
`default_nettype wire

### src/stbe_ctrl.sv
// Controller: sequences receive compare, root election, port update and emit.
// Depends on stbe_pkg.
`default_nettype none
module stbe_ctrl #(
  parameter int PORTS = 8
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire stbe_pkg::status_t          status_i,
  input  wire logic [$clog2(PORTS+1)-1:0] n_act_i,
  output stbe_pkg::cmd_t                  cmd_o,
  output logic [$clog2(PORTS+1)-1:0]      idx_o
);
  import stbe_pkg::*;

  localparam int CW = $clog2(PORTS + 1);

  state_e state_q, state_d;
  logic [CW-1:0] idx_q, idx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DISP;
        end
      end
      S_DISP: begin
        if (status_i.mode) begin
          state_d = status_i.hello_en ? S_EM_START : S_IDLE;
        end else begin
          state_d = status_i.rx_active ? S_RX_RD : S_IDLE;
        end
      end
      S_RX_RD: begin
        cmd_o.rd    = 1'b1;
        cmd_o.rd_rx = 1'b1;
        state_d     = S_RX_CMP;
      end
      S_RX_CMP: begin
        idx_d = '0;
        if (status_i.rx_equal) begin
          state_d = S_IDLE;
        end else if (status_i.rx_better) begin
          cmd_o.wr_rx    = 1'b1;
          cmd_o.best_clr = 1'b1;
          state_d        = S_EL_RD;
        end else begin
          state_d = S_EM_START;
        end
      end
      S_EL_RD: begin
        if (idx_q < n_act_i) begin
          cmd_o.rd = 1'b1;
          state_d  = S_EL_EV;
        end else begin
          state_d = S_ROOT;
        end
      end
      S_EL_EV: begin
        cmd_o.el_eval = 1'b1;
        idx_d         = idx_q + 1'b1;
        state_d       = S_EL_RD;
      end
      S_ROOT: begin
        cmd_o.root_set = 1'b1;
        idx_d          = '0;
        state_d        = S_UP_RD;
      end
      S_UP_RD: begin
        if (idx_q < n_act_i) begin
          cmd_o.rd = 1'b1;
          state_d  = S_UP_EV;
        end else begin
          state_d = S_EM_START;
        end
      end
      S_UP_EV: begin
        cmd_o.upd_eval = 1'b1;
        idx_d          = idx_q + 1'b1;
        state_d        = S_UP_RD;
      end
      S_EM_START: begin
        cmd_o.emit_start = 1'b1;
        state_d          = S_EMIT;
      end
      S_EMIT: begin
        if (status_i.rem_empty) begin
          state_d = S_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.emit_load = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign idx_o = idx_q;

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second item taken while one is in work");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_load |-> (status_i.out_free && !status_i.rem_empty))
    else $error("result loaded into a busy or empty slot");

  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.wr_rx && cmd_o.upd_eval))
    else $error("two memory writes in one cycle");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd |-> (cmd_o.rd_rx || idx_q < n_act_i))
    else $error("walk read beyond active ports");

endmodule
`default_nettype wire

### verif/tb_spanning_tree_bpdu_engine.sv
// Self-checking testbench for spanning_tree_bpdu_engine: random and directed config
// messages and hello ticks, checked against an in-bench spanning-tree predictor.
// Depends on stbe_pkg and the engine RTL.
`timescale 1ns / 1ps
module tb_spanning_tree_bpdu_engine;
  import stbe_pkg::*;

  localparam int NPORT = 8;
  localparam int WATCHDOG = 20000;
  localparam logic MODE_CFG = 1'b0;
  localparam logic MODE_HELLO = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [2:0]  port;
    logic [63:0] root;
    logic [31:0] cost;
    logic [63:0] sw;
    logic [15:0] sport;
  } msg_t;

  typedef struct packed {
    logic [2:0]  port;
    logic [63:0] root;
    logic [31:0] cost;
    logic [63:0] sw;
    logic [15:0] pid;
    logic        rpv;
    logic [2:0]  rpi;
    logic        last;
  } bpdu_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic mode_i = 1'b0;
  logic [2:0] rx_port_i = '0;
  logic [63:0] rx_root_id_i = '0;
  logic [31:0] rx_root_cost_i = '0;
  logic [63:0] rx_switch_id_i = '0;
  logic [15:0] rx_sender_port_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [2:0] tx_port_o;
  logic [63:0] tx_root_id_o;
  logic [31:0] tx_root_cost_o;
  logic [63:0] tx_switch_id_o;
  logic [15:0] tx_port_id_o;
  logic root_port_valid_o;
  logic [2:0] root_port_index_o;
  logic last_o;

  spanning_tree_bpdu_engine #(.PORTS(NPORT)) uut (.*);

  always #2 clk_i = ~clk_i;

  // Predictor state: bridge registers and per-port best vectors
  logic [63:0] bridge_id;
  logic [7:0]  prio;
  logic [3:0]  nports;
  logic [15:0] link_cost;
  vec_t        best_vec [NPORT];
  logic [63:0] cur_root;
  logic [31:0] cur_cost;
  logic [2:0]  rp_idx;
  logic        rp_ok;
  logic        hello_on;

  msg_t  pending_msgs[$];
  bpdu_t expected_bpdus[$];
  int    errors = 0;
  int    n_sent = 0;
  int    n_rcvd = 0;
  int    n_hello = 0;
  int    idle_cnt = 0;
  logic  tx_hold = 1'b0;   // sender pause request from the stimulus
  int    in_gap = 0;
  int    out_gap = 0;

  function automatic logic [15:0] own_pid(int i);
    return {prio, 8'(i + 1)};
  endfunction

  function automatic int active_cnt();
    return (nports > NPORT) ? NPORT : int'(nports);
  endfunction

  function automatic bit designated(int i);
    return best_vec[i].sw == bridge_id && best_vec[i].port == own_pid(i);
  endfunction

  function automatic void clear_tree();
    for (int i = 0; i < NPORT; i++) best_vec[i] = '{bridge_id, 32'd0, bridge_id, own_pid(i)};
    cur_root = bridge_id;
    cur_cost = '0;
    rp_idx = '0;
    rp_ok = 1'b0;
    hello_on = 1'b1;
  endfunction

  function automatic void queue_bpdus();
    int cnt;
    cnt = 0;
    if (cur_root != bridge_id && !rp_ok) return;
    for (int i = 0; i < active_cnt(); i++) begin
      if (designated(i)) begin
        expected_bpdus.push_back('{3'(i), cur_root, cur_cost, bridge_id, own_pid(i),
                                   rp_ok, rp_ok ? rp_idx : 3'd0, 1'b0});
        cnt++;
      end
    end
    if (cnt > 0) expected_bpdus[$].last = 1'b1;
  endfunction

  function automatic void elect_ports();
    int sel;
    bit was_root;
    bit take;
    logic [32:0] sum;
    sel = -1;
    was_root = (cur_root == bridge_id);
    for (int i = 0; i < active_cnt(); i++) begin
      if (designated(i) || best_vec[i].root >= bridge_id) continue;
      if (sel < 0 || best_vec[i] < best_vec[sel]) sel = i;
    end
    if (sel < 0) begin
      cur_root = bridge_id;
      cur_cost = '0;
      rp_ok = 1'b0;
      rp_idx = '0;
    end else begin
      sum = {1'b0, best_vec[sel].cost} + link_cost;
      cur_root = best_vec[sel].root;
      cur_cost = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      rp_ok = 1'b1;
      rp_idx = 3'(sel);
    end
    for (int i = 0; i < active_cnt(); i++) begin
      if (rp_ok && i == rp_idx) continue;
      take = designated(i) || best_vec[i].root != cur_root || cur_cost < best_vec[i].cost ||
             (cur_cost == best_vec[i].cost &&
              (bridge_id < best_vec[i].sw ||
               (bridge_id == best_vec[i].sw && own_pid(i) <= best_vec[i].port)));
      if (take) best_vec[i] = '{cur_root, cur_cost, bridge_id, own_pid(i)};
    end
    if (was_root && cur_root != bridge_id) hello_on = 1'b0;
    if (!was_root && cur_root == bridge_id) hello_on = 1'b1;
  endfunction

  // Model one accepted transfer on the input channel
  function automatic void predict_msg(msg_t m);
    vec_t rx;
    if (m.mode == MODE_HELLO) begin
      if (hello_on) queue_bpdus();
      return;
    end
    if (int'(m.port) >= active_cnt()) return;
    rx = '{m.root, m.cost, m.sw, m.sport};
    if (rx == best_vec[m.port]) return;
    if (rx < best_vec[m.port]) begin
      best_vec[m.port] = rx;
      elect_ports();
    end
    queue_bpdus();
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Driver: holds the payload until accepted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_msg('{mode_i, rx_port_i, rx_root_id_i, rx_root_cost_i, rx_switch_id_i,
                      rx_sender_port_i});
        n_sent++;
        if (mode_i == MODE_HELLO) n_hello++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_msgs.size() > 0 && !tx_hold) begin
          in_valid_i <= 1'b1;
          {mode_i, rx_port_i, rx_root_id_i, rx_root_cost_i, rx_switch_id_i,
           rx_sender_port_i} <= pending_msgs.pop_front();
          in_gap = gap_len();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: random output stalls and field-by-field compare
  always @(posedge clk_i) begin
    bpdu_t e;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        n_rcvd++;
        if (expected_bpdus.size() == 0) begin
          $error("unexpected result on port %0d", tx_port_o);
          errors++;
        end else begin
          e = expected_bpdus.pop_front();
          if (tx_port_o !== e.port) begin
            $error("tx_port exp %0d got %0d", e.port, tx_port_o); errors++;
          end
          if (tx_root_id_o !== e.root) begin
            $error("tx_root_id exp %h got %h", e.root, tx_root_id_o); errors++;
          end
          if (tx_root_cost_o !== e.cost) begin
            $error("tx_root_cost exp %h got %h", e.cost, tx_root_cost_o); errors++;
          end
          if (tx_switch_id_o !== e.sw) begin
            $error("tx_switch_id exp %h got %h", e.sw, tx_switch_id_o); errors++;
          end
          if (tx_port_id_o !== e.pid) begin
            $error("tx_port_id exp %h got %h", e.pid, tx_port_id_o); errors++;
          end
          if (root_port_valid_o !== e.rpv) begin
            $error("root_port_valid exp %0d got %0d", e.rpv, root_port_valid_o); errors++;
          end
          if (root_port_index_o !== e.rpi) begin
            $error("root_port_index exp %0d got %0d", e.rpi, root_port_index_o); errors++;
          end
          if (last_o !== e.last) begin
            $error("last exp %0d got %0d", e.last, last_o); errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        out_gap = gap_len();
      end
    end
  end

  // Watchdog: cycles with no transfer on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WATCHDOG) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_msgs.size() > 0 || in_valid_i || expected_bpdus.size() > 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);  // trailing work of items that emit nothing
  endtask

  task automatic write_reg(reg_e idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_OWN_ID: begin bridge_id = val; clear_tree(); end
      REG_PORT_PRIO: begin prio = val[7:0]; clear_tree(); end
      REG_PORTS_USED: nports = val[3:0];
      default: link_cost = val[15:0];
    endcase
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Mostly plausible vectors near our own id so elections actually change
  function automatic msg_t rand_msg();
    msg_t m;
    int k;
    m.mode = ($urandom_range(0, 9) == 0) ? MODE_HELLO : MODE_CFG;
    m.port = 3'($urandom_range(0, 7));
    k = $urandom_range(0, 9);
    if (k < 7) begin
      m.root = bridge_id - 64'($urandom_range(0, 4));
      m.cost = $urandom_range(0, 6);
      m.sw = bridge_id + 64'($urandom_range(0, 3)) - 64'd1;
      m.sport = 16'($urandom_range(0, 16'hFFFF));
    end else if (k < 8) begin
      m.root = best_vec[m.port].root;
      m.cost = best_vec[m.port].cost;
      m.sw = best_vec[m.port].sw;
      m.sport = best_vec[m.port].port;
    end else begin
      m.root = rand64();
      m.cost = (k == 9) ? 32'hFFFF_FFF0 + $urandom_range(0, 15) : $urandom();
      m.sw = rand64();
      m.sport = 16'($urandom());
    end
    return m;
  endfunction

  initial begin
    msg_t m;
    bridge_id = '0;
    prio = 8'd128;
    nports = 4'd8;
    link_cost = 16'd1;
    clear_tree();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extreme settings and the named corner cases
    write_reg(REG_OWN_ID, 64'h8000_0000_0000_1000);
    write_reg(REG_PORT_PRIO, 64'd255);
    write_reg(REG_PATH_COST, 64'd65535);
    write_reg(REG_PORTS_USED, 64'd8);
    pending_msgs.push_back('{MODE_HELLO, 3'd0, '0, '0, '0, '0});
    pending_msgs.push_back('{MODE_CFG, 3'd2, 64'h10, 32'hFFFF_FFFF, 64'h20, 16'h8001});
    pending_msgs.push_back('{MODE_CFG, 3'd2, 64'h10, 32'hFFFF_FFFF, 64'h20, 16'h8001});
    pending_msgs.push_back('{MODE_CFG, 3'd2, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF,
                            64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF});
    pending_msgs.push_back('{MODE_CFG, 3'd5, 64'h0, 32'h0, 64'h0, 16'h0});
    pending_msgs.push_back('{MODE_HELLO, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF,
                            64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF});
    pending_msgs.push_back('{MODE_CFG, 3'd7, 64'h0, 32'h0, 64'h0, 16'h1});
    wait_drained();
    write_reg(REG_PORTS_USED, 64'd2);
    pending_msgs.push_back('{MODE_CFG, 3'd6, 64'h5, 32'h1, 64'h5, 16'h1});
    pending_msgs.push_back('{MODE_CFG, 3'd1, 64'h5, 32'h1, 64'h5, 16'h1});
    pending_msgs.push_back('{MODE_HELLO, 3'd0, '0, '0, '0, '0});
    wait_drained();
    write_reg(REG_PORTS_USED, 64'd0);
    pending_msgs.push_back('{MODE_CFG, 3'd0, 64'h1, 32'h1, 64'h1, 16'h1});
    pending_msgs.push_back('{MODE_HELLO, 3'd0, '0, '0, '0, '0});
    wait_drained();
    write_reg(REG_PORTS_USED, 64'd15);  // clamps to the port count

    // Random phases under several settings; each ends fully drained
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_reg(REG_OWN_ID, 64'hFFFF_FFFF_FFFF_FFFF);
        1: write_reg(REG_OWN_ID, 64'h0);
        2: write_reg(REG_OWN_ID, rand64());
        default: write_reg(REG_OWN_ID, 64'h0000_0000_0000_0100 + $urandom_range(0, 255));
      endcase
      write_reg(REG_PORT_PRIO, 64'($urandom_range(0, 255)));
      write_reg(REG_PORTS_USED, (ph == 1) ? 64'd1 : 64'($urandom_range(1, 8)));
      write_reg(REG_PATH_COST, (ph == 2) ? 64'd1 : 64'($urandom_range(1, 65535)));
      for (int n = 0; n < 50; n++) begin
        // Compute random content against current stored state when queued
        m = rand_msg();
        pending_msgs.push_back(m);
        if (n == 25) begin
          // Hold off the sender until all results so far are in
          while (pending_msgs.size() > 0 || in_valid_i) @(posedge clk_i);
          tx_hold = 1'b1;
          while (expected_bpdus.size() > 0) @(posedge clk_i);
          tx_hold = 1'b0;
        end
      end
      wait_drained();
    end

    $display("Covered %0d input transfers (%0d hello ticks), %0d results checked.",
             n_sent, n_hello, n_rcvd);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

### filelist.f
src/stbe_pkg.sv
src/stbe_dp.sv
src/stbe_ctrl.sv
src/spanning_tree_bpdu_engine.sv
verif/tb_spanning_tree_bpdu_engine.sv
